// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the joint angle block
// used by modules that clock on aclk and reset on aresetn
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/jabs_pkg.sv =====
// shared types, constants and the arctangent table of the joint angle block
// no dependencies
package jabs_pkg;

    localparam int SC_W      = 30;   // scaled cross and dot, signed, magnitude below 2^29
    localparam int SQ_W      = 60;   // sum of squares of scaled cross components
    localparam int ROOT_W    = 30;   // cross length
    localparam int SQ_STEPS  = 30;   // one result bit per square root stage
    localparam int XY_W      = 34;   // cordic x and y, room for the gain
    localparam int Z_W       = 25;   // angle accumulator, centidegrees with 8 fraction bits
    localparam int ANG_FRAC  = 8;
    localparam int ANG_W     = 15;
    localparam int TAB_W     = 21;
    localparam int TAB_LEN   = 24;
    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(2304000);
    localparam logic signed [Z_W-1:0] Z_MAX     = Z_W'(18000 * 256);
    localparam logic [1:0] TRK_NONE = 2'd0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNTRACKED = 2'd1,
        ST_DEGEN     = 2'd2
    } status_t;

    typedef struct packed {
        status_t                 status;
        logic signed [SC_W-1:0]  dot;
    } side_t;

    // atan(2^-i) in centidegrees with 8 fraction bits
    function automatic logic [TAB_W-1:0] atan_entry(input int i);
        logic [TAB_W-1:0] e;
        begin
            unique case (i)
                0:  e = TAB_W'(1152000);
                1:  e = TAB_W'(680065);
                2:  e = TAB_W'(359328);
                3:  e = TAB_W'(182400);
                4:  e = TAB_W'(91554);
                5:  e = TAB_W'(45822);
                6:  e = TAB_W'(22916);
                7:  e = TAB_W'(11459);
                8:  e = TAB_W'(5730);
                9:  e = TAB_W'(2865);
                10: e = TAB_W'(1432);
                11: e = TAB_W'(716);
                12: e = TAB_W'(358);
                13: e = TAB_W'(179);
                14: e = TAB_W'(90);
                15: e = TAB_W'(45);
                16: e = TAB_W'(22);
                17: e = TAB_W'(11);
                18: e = TAB_W'(6);
                19: e = TAB_W'(3);
                20: e = TAB_W'(1);
                21: e = TAB_W'(1);
                default: e = '0;
            endcase
            return e;
        end
    endfunction

endpackage

// ===== rtl/core/jabs_prep.sv =====
// segment vectors, cross and dot products, and block scaling to 29-bit magnitudes
// depends on jabs_pkg
module jabs_prep #(
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [47:0]                   seg1_near_point,
    input  logic [47:0]                   seg1_far_point,
    input  logic [47:0]                   seg2_near_point,
    input  logic [47:0]                   seg2_far_point,
    input  logic [1:0]                    seg1_tracking,
    input  logic [1:0]                    seg2_tracking,
    output logic                          out_valid,
    output logic signed [jabs_pkg::SC_W-1:0] cross_x,
    output logic signed [jabs_pkg::SC_W-1:0] cross_y,
    output logic signed [jabs_pkg::SC_W-1:0] cross_z,
    output jabs_pkg::side_t               out_side
);
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;
    localparam int VW    = PW + 2;
    localparam int SHW   = $clog2(VW + 1);
    localparam int EXT_W = 3 * COORD_BITS + 48;
    localparam int LIM   = 29;

    function automatic logic signed [DW-1:0] coord(input logic [47:0] p, input int k);
        logic [EXT_W-1:0] ext;
        logic signed [COORD_BITS-1:0] c;
        begin
            ext = {{(3 * COORD_BITS){1'b0}}, p};
            c   = $signed(ext[k * COORD_BITS +: COORD_BITS]);
            return DW'(c);
        end
    endfunction

    logic [8:1] v_reg;
    jabs_pkg::status_t st_reg [1:8];
    logic signed [jabs_pkg::SC_W-1:0] dot_out_reg;

    // stage 1: differences and status
    logic signed [DW-1:0] a_next [3], b_next [3];
    jabs_pkg::status_t st1_next;
    logic signed [DW-1:0] a_reg [3], b_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_next[k] = coord(seg1_near_point, k) - coord(seg1_far_point, k);
            b_next[k] = coord(seg2_far_point, k) - coord(seg2_near_point, k);
        end
        if (seg1_tracking == jabs_pkg::TRK_NONE || seg2_tracking == jabs_pkg::TRK_NONE) begin
            st1_next = jabs_pkg::ST_UNTRACKED;
        end else if ((a_next[0] == '0 && a_next[1] == '0 && a_next[2] == '0) ||
                     (b_next[0] == '0 && b_next[1] == '0 && b_next[2] == '0)) begin
            st1_next = jabs_pkg::ST_DEGEN;
        end else begin
            st1_next = jabs_pkg::ST_OK;
        end
    end

    // stage 2: nine products, stage 3: sums
    logic signed [PW-1:0] p_reg [9];
    logic signed [VW-1:0] val_reg [4];   // cross x, y, z, dot
    // stage 4: magnitudes, stages 5 and 6: maximum, stage 7: shift amount
    logic [VW-1:0] mag_reg [4];
    logic [3:0]    sgn4_reg, sgn5_reg, sgn6_reg, sgn7_reg;
    logic [VW-1:0] mag5_reg [4], mag6_reg [4], mag7_reg [4];
    logic [VW-1:0] mx01_reg, mx23_reg, mx_reg;
    logic [SHW-1:0] sh_next, sh_reg;
    logic signed [jabs_pkg::SC_W-1:0] sc_next [4];
    logic signed [jabs_pkg::SC_W-1:0] sc_reg [3];

    always_comb begin
        sh_next = '0;
        for (int i = 0; i < VW; i++) begin
            if (mx_reg[i] && i >= LIM) begin
                sh_next = SHW'(i + 1 - LIM);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sc_next[k] = jabs_pkg::SC_W'(mag7_reg[k] >> sh_reg);
            if (sgn7_reg[k]) begin
                sc_next[k] = -sc_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[7:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[1] <= st1_next;
            for (int i = 2; i <= 8; i++) begin
                st_reg[i] <= st_reg[i - 1];
            end
            a_reg <= a_next;
            b_reg <= b_next;
            p_reg[0] <= a_reg[1] * b_reg[2];
            p_reg[1] <= a_reg[2] * b_reg[1];
            p_reg[2] <= a_reg[2] * b_reg[0];
            p_reg[3] <= a_reg[0] * b_reg[2];
            p_reg[4] <= a_reg[0] * b_reg[1];
            p_reg[5] <= a_reg[1] * b_reg[0];
            p_reg[6] <= a_reg[0] * b_reg[0];
            p_reg[7] <= a_reg[1] * b_reg[1];
            p_reg[8] <= a_reg[2] * b_reg[2];
            val_reg[0] <= VW'(p_reg[0]) - VW'(p_reg[1]);
            val_reg[1] <= VW'(p_reg[2]) - VW'(p_reg[3]);
            val_reg[2] <= VW'(p_reg[4]) - VW'(p_reg[5]);
            val_reg[3] <= VW'(p_reg[6]) + VW'(p_reg[7]) + VW'(p_reg[8]);
            for (int k = 0; k < 4; k++) begin
                mag_reg[k]  <= val_reg[k][VW-1] ? VW'(-val_reg[k]) : VW'(val_reg[k]);
                sgn4_reg[k] <= val_reg[k][VW-1];
            end
            mag5_reg <= mag_reg;
            sgn5_reg <= sgn4_reg;
            mx01_reg <= (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
            mx23_reg <= (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
            mag6_reg <= mag5_reg;
            sgn6_reg <= sgn5_reg;
            mx_reg   <= (mx01_reg > mx23_reg) ? mx01_reg : mx23_reg;
            mag7_reg <= mag6_reg;
            sgn7_reg <= sgn6_reg;
            sh_reg   <= sh_next;
            sc_reg[0]   <= sc_next[0];
            sc_reg[1]   <= sc_next[1];
            sc_reg[2]   <= sc_next[2];
            dot_out_reg <= sc_next[3];
        end
    end

    assign out_valid       = v_reg[8];
    assign cross_x         = sc_reg[0];
    assign cross_y         = sc_reg[1];
    assign cross_z         = sc_reg[2];
    assign out_side.status = st_reg[8];
    assign out_side.dot    = dot_out_reg;
endmodule

// ===== rtl/core/jabs_isqrt.sv =====
// length of the scaled cross product: squares, sum and a one-bit-per-stage square root
// depends on jabs_pkg
module jabs_isqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [jabs_pkg::SC_W-1:0]  cross_x,
    input  logic signed [jabs_pkg::SC_W-1:0]  cross_y,
    input  logic signed [jabs_pkg::SC_W-1:0]  cross_z,
    input  jabs_pkg::side_t                   in_side,
    output logic                              out_valid,
    output logic [jabs_pkg::ROOT_W-1:0]       root,
    output jabs_pkg::side_t                   out_side
);
    localparam int N  = jabs_pkg::SQ_STEPS;
    localparam int QW = jabs_pkg::SQ_W;

    logic [N+1:0]       v_reg;
    jabs_pkg::side_t    side_reg [N+2];
    logic [QW-1:0]      sq_reg [3];
    logic [QW-1:0]      n_reg [N+1];
    logic [QW-1:0]      r_reg [N+1];
    logic [QW-1:0]      n_next [N];
    logic [QW-1:0]      r_next [N];

    // restoring square root, bit weight 4^(N-1-j) at stage j
    always_comb begin
        logic [QW-1:0] bitw;
        for (int j = 0; j < N; j++) begin
            bitw = QW'(1) << (2 * (N - 1 - j));
            if (n_reg[j] >= r_reg[j] + bitw) begin
                n_next[j] = n_reg[j] - (r_reg[j] + bitw);
                r_next[j] = (r_reg[j] >> 1) + bitw;
            end else begin
                n_next[j] = n_reg[j];
                r_next[j] = r_reg[j] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int i = 1; i < N + 2; i++) begin
                side_reg[i] <= side_reg[i - 1];
            end
            // full-width signed squares
            sq_reg[0] <= cross_x * cross_x;
            sq_reg[1] <= cross_y * cross_y;
            sq_reg[2] <= cross_z * cross_z;
            n_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            r_reg[0]  <= '0;
            for (int j = 0; j < N; j++) begin
                n_reg[j + 1] <= n_next[j];
                r_reg[j + 1] <= r_next[j];
            end
        end
    end

    assign out_valid = v_reg[N + 1];
    assign root      = r_reg[N][jabs_pkg::ROOT_W-1:0];
    assign out_side  = side_reg[N + 1];
endmodule

// ===== rtl/core/jabs_cordic.sv =====
// vectoring cordic for atan2(cross length, dot) and rounding to centidegrees
// depends on jabs_pkg
module jabs_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [jabs_pkg::ROOT_W-1:0]     root,
    input  jabs_pkg::side_t                 in_side,
    output logic                            out_valid,
    output logic [jabs_pkg::ANG_W-1:0]      angle_centideg,
    output jabs_pkg::status_t               angle_status
);
    localparam int S  = CORDIC_STEPS;
    localparam int XW = jabs_pkg::XY_W;
    localparam int ZW = jabs_pkg::Z_W;

    logic [S+1:0]              v_reg;
    jabs_pkg::status_t         st_reg [S+1];
    logic signed [XW-1:0]      x_reg [S+1], y_reg [S+1];
    logic signed [ZW-1:0]      z_reg [S+1];
    logic signed [XW-1:0]      x_next [S], y_next [S];
    logic signed [ZW-1:0]      z_next [S];
    logic signed [ZW-1:0]      zc;
    logic [ZW-1:0]             rounded;
    logic [jabs_pkg::ANG_W-1:0] ang_reg;
    jabs_pkg::status_t         st_out_reg;

    always_comb begin
        logic signed [XW-1:0] xs, ys;
        for (int k = 0; k < S; k++) begin
            xs = x_reg[k] >>> k;
            ys = y_reg[k] >>> k;
            if (!y_reg[k][XW-1] && y_reg[k] != '0) begin
                x_next[k] = x_reg[k] + ys;
                y_next[k] = y_reg[k] - xs;
                z_next[k] = z_reg[k] + ZW'(jabs_pkg::atan_entry(k));
            end else begin
                x_next[k] = x_reg[k] - ys;
                y_next[k] = y_reg[k] + xs;
                z_next[k] = z_reg[k] - ZW'(jabs_pkg::atan_entry(k));
            end
        end
    end

    always_comb begin
        if (z_reg[S][ZW-1]) begin
            zc = '0;
        end else if (z_reg[S] > jabs_pkg::Z_MAX) begin
            zc = jabs_pkg::Z_MAX;
        end else begin
            zc = z_reg[S];
        end
        rounded = (ZW'(zc) + ZW'(1 << (jabs_pkg::ANG_FRAC - 1))) >> jabs_pkg::ANG_FRAC;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[S:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= in_side.status;
            // negative dot: turn by a quarter first
            if (in_side.dot[jabs_pkg::SC_W-1]) begin
                x_reg[0] <= XW'($signed({1'b0, root}));
                y_reg[0] <= -XW'(in_side.dot);
                z_reg[0] <= jabs_pkg::Z_QUARTER;
            end else begin
                x_reg[0] <= XW'(in_side.dot);
                y_reg[0] <= XW'($signed({1'b0, root}));
                z_reg[0] <= '0;
            end
            for (int k = 0; k < S; k++) begin
                st_reg[k + 1] <= st_reg[k];
                x_reg[k + 1]  <= x_next[k];
                y_reg[k + 1]  <= y_next[k];
                z_reg[k + 1]  <= z_next[k];
            end
            st_out_reg <= st_reg[S];
            ang_reg    <= (st_reg[S] == jabs_pkg::ST_OK) ?
                          rounded[jabs_pkg::ANG_W-1:0] : '0;
        end
    end

    assign out_valid      = v_reg[S + 1];
    assign angle_centideg = ang_reg;
    assign angle_status   = st_out_reg;
endmodule

// ===== rtl/core/joint_angle_between_segments.sv =====
// Joint angle between two body segments. One request carries four packed 3D joints and two
// tracking states; one result gives the angle in centidegrees (0..18000) and a status.
// An item can enter every cycle unless the output stalls; it passes the scaling stages,
// the square root stages (one result bit each) and cordic stages (one rotation each). The whole
// pipeline holds while a result waits at the output. Depends on jabs_pkg and the stage modules.
`include "assert_macros.svh"
module joint_angle_between_segments #(
    parameter int COORD_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // seg1_near_point, seg1_far_point, seg2_near_point, seg2_far_point (48 bits each)
    input  logic [191:0] s_tdata,
    // seg1_tracking, seg2_tracking
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // angle_centideg (15 bits), one zero pad bit
    output logic [15:0]  m_tdata,
    // angle_status
    output logic [1:0]   m_tuser
);
    logic en;
    logic p_valid, q_valid;
    logic signed [jabs_pkg::SC_W-1:0] cx, cy, cz;
    jabs_pkg::side_t p_side, q_side;
    logic [jabs_pkg::ROOT_W-1:0] root;
    logic [jabs_pkg::ANG_W-1:0] angle;
    jabs_pkg::status_t status;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    jabs_prep #(.COORD_BITS(COORD_BITS)) u_prep (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .seg1_near_point(s_tdata[47:0]), .seg1_far_point(s_tdata[95:48]),
        .seg2_near_point(s_tdata[143:96]), .seg2_far_point(s_tdata[191:144]),
        .seg1_tracking(s_tuser[1:0]), .seg2_tracking(s_tuser[3:2]),
        .out_valid(p_valid), .cross_x(cx), .cross_y(cy), .cross_z(cz), .out_side(p_side)
    );

    jabs_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p_valid),
        .cross_x(cx), .cross_y(cy), .cross_z(cz), .in_side(p_side),
        .out_valid(q_valid), .root(root), .out_side(q_side)
    );

    jabs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(q_valid),
        .root(root), .in_side(q_side),
        .out_valid(m_tvalid), .angle_centideg(angle), .angle_status(status)
    );

    assign m_tdata = {1'b0, angle};
    assign m_tuser = status;

    `ASSERT_IMPLIES(a_angle_range, m_tvalid, angle <= jabs_pkg::ANG_W'(18000), "angle above 180 degrees")
    `ASSERT_IMPLIES(a_flag_zero, m_tvalid && status != jabs_pkg::ST_OK, angle == '0, "flagged result has nonzero angle")
    `ASSERT_IMPLIES(a_stall_holds, m_tvalid && !m_tready, s_tready == 1'b0, "input taken while output stalled")
endmodule

// ===== bench/joint_angle_between_segments_tb.sv =====
// Self-checking bench for the joint angle block: directed table, then random requests.
// Expected angles come from an integer predictor in this file; depends on jabs_pkg.
`timescale 1ns / 100ps
module joint_angle_between_segments_tb;

    localparam int CB = 16;
    localparam int STEPS = 16;
    localparam int LAT = 8 + 32 + STEPS + 2;
    localparam int N_RAND = 1400;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [47:0] pt [4];
        logic [1:0]  trk1;
        logic [1:0]  trk2;
        logic        known;
        logic [14:0] ang;
        jabs_pkg::status_t st;
    } row_t;

    typedef struct {
        logic [14:0] ang;
        jabs_pkg::status_t st;
    } angle_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic [1:0]   m_tuser;

    angle_t pending_angles [$];
    int     mismatches = 0;
    longint cycles = 0;

    joint_angle_between_segments #(.COORD_BITS(CB), .CORDIC_STEPS(STEPS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint coord(logic [47:0] p, int k);
        logic [CB-1:0] raw;
        raw = p[k*CB +: CB];
        return longint'($signed(raw));
    endfunction

    function automatic longint shift_mag(longint v, int s);
        longint m;
        m = (v < 0 ? -v : v) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic angle_t predict_angle(logic [47:0] p [4], logic [1:0] t1, logic [1:0] t2);
        angle_t r;
        longint a [3], b [3], c [3], d, x, y, z, t, xs, ys, mx;
        logic z1, z2;
        int s;
        r.ang = '0;
        z1 = 1'b1;
        z2 = 1'b1;
        if (t1 == jabs_pkg::TRK_NONE || t2 == jabs_pkg::TRK_NONE) begin
            r.st = jabs_pkg::ST_UNTRACKED;
            return r;
        end
        for (int k = 0; k < 3; k++) begin
            a[k] = coord(p[0], k) - coord(p[1], k);
            b[k] = coord(p[3], k) - coord(p[2], k);
            if (a[k] != 0) z1 = 1'b0;
            if (b[k] != 0) z2 = 1'b0;
        end
        if (z1 || z2) begin
            r.st = jabs_pkg::ST_DEGEN;
            return r;
        end
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        mx = d < 0 ? -d : d;
        for (int k = 0; k < 3; k++)
            if ((c[k] < 0 ? -c[k] : c[k]) > mx) mx = c[k] < 0 ? -c[k] : c[k];
        s = 0;
        while ((mx >>> s) >= 64'd536870912) s++;
        for (int k = 0; k < 3; k++) c[k] = shift_mag(c[k], s);
        d = shift_mag(d, s);
        y = root_floor(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
        x = d;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 2304000;
        end
        for (int k = 0; k < STEPS && k < jabs_pkg::TAB_LEN; k++) begin
            xs = x >>> k;   // arithmetic floor shift
            ys = y >>> k;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += longint'(jabs_pkg::atan_entry(k));
            end else begin
                x -= ys;
                y += xs;
                z -= longint'(jabs_pkg::atan_entry(k));
            end
        end
        if (z < 0) z = 0;
        if (z > 18000 * 256) z = 18000 * 256;
        r.ang = 15'((z + 128) >>> 8);
        r.st = jabs_pkg::ST_OK;
        return r;
    endfunction

    function automatic logic [47:0] pack_pt(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [15:0] rand_coord();
        // mostly small values, sometimes any value, sometimes an extreme
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic send_request(row_t r);
        angle_t e;
        int idle;
        idle = $urandom_range(0, 19);
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        if (r.known) begin
            e.ang = r.ang;
            e.st = r.st;
        end else begin
            e = predict_angle(r.pt, r.trk1, r.trk2);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.pt[3], r.pt[2], r.pt[1], r.pt[0]};
        s_tuser <= {r.trk2, r.trk1};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_angles = {pending_angles, e};
    endtask

    // receiver with random stalls
    initial begin
        angle_t e;
        int idle;
        @(posedge aresetn);
        forever begin
            idle = $urandom_range(0, 19);
            if (idle > 0) begin
                m_tready <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result angle=%0d status=%0d", m_tdata[14:0], m_tuser);
            end else begin
                e = pending_angles.pop_front();
                if (m_tdata[14:0] !== e.ang || m_tuser !== e.st || m_tdata[15] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("angle mismatch: expected %0d/%0d got %0d/%0d",
                                 e.ang, e.st, m_tdata[14:0], m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        row_t r;
        row_t directed [$];
        int tail;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        r.known = 1'b0;
        r.trk1 = 2'd2;
        r.trk2 = 2'd2;
        // opposite, parallel, right angle
        r.pt = '{pack_pt(100, 0, 0), pack_pt(0, 0, 0), pack_pt(0, 0, 0), pack_pt(-50, 0, 0)};
        directed = {directed, r};
        r.pt = '{pack_pt(100, 0, 0), pack_pt(0, 0, 0), pack_pt(0, 0, 0), pack_pt(50, 0, 0)};
        directed = {directed, r};
        r.pt = '{pack_pt(0, 0, 0), pack_pt(0, 0, 10), pack_pt(0, 0, 0), pack_pt(0, 7, 0)};
        directed = {directed, r};
        // full-scale and all-ones coordinates
        r.pt = '{pack_pt(32767, 32767, 32767), pack_pt(-32768, -32768, -32768),
                 pack_pt(-32768, 32767, -32768), pack_pt(32767, -32768, 32767)};
        directed = {directed, r};
        r.pt = '{pack_pt(32767, -32768, 0), pack_pt(-32768, 32767, 0),
                 pack_pt(-32768, -32768, 32767), pack_pt(32767, 32767, -32768)};
        directed = {directed, r};
        r.pt = '{48'hffffffffffff, 48'h0, 48'h0, 48'hffffffffffff};
        directed = {directed, r};
        // out-of-range tracking value counts as tracked
        r.trk1 = 2'd3;
        r.trk2 = 2'd1;
        r.pt = '{pack_pt(3, 4, 5), pack_pt(0, 0, 0), pack_pt(1, 1, 1), pack_pt(-2, 6, 9)};
        directed = {directed, r};
        // untracked segments, checked before zero length
        r.known = 1'b1;
        r.ang = '0;
        r.st = jabs_pkg::ST_UNTRACKED;
        r.trk1 = jabs_pkg::TRK_NONE;
        r.trk2 = 2'd2;
        directed = {directed, r};
        r.trk1 = 2'd3;
        r.trk2 = jabs_pkg::TRK_NONE;
        directed = {directed, r};
        r.pt = '{48'h0, 48'h0, 48'h0, 48'h0};
        r.trk1 = jabs_pkg::TRK_NONE;
        directed = {directed, r};
        // zero-length vectors
        r.st = jabs_pkg::ST_DEGEN;
        r.trk1 = 2'd2;
        r.trk2 = 2'd2;
        directed = {directed, r};
        r.pt = '{pack_pt(5, 5, 5), pack_pt(5, 5, 5), pack_pt(0, 0, 0), pack_pt(1, 0, 0)};
        directed = {directed, r};
        r.pt = '{pack_pt(5, 0, 0), pack_pt(0, 0, 0), pack_pt(-9, 9, 9), pack_pt(-9, 9, 9)};
        directed = {directed, r};

        foreach (directed[i]) send_request(directed[i]);
        s_tvalid <= 1'b0;

        // hold off until the pipeline has drained
        while (pending_angles.size() != 0) @(posedge aclk);

        r.known = 1'b0;
        for (int n = 0; n < N_RAND; n++) begin
            for (int k = 0; k < 4; k++)
                r.pt[k] = {rand_coord(), rand_coord(), rand_coord()};
            // occasionally make a segment zero length
            if ($urandom_range(0, 19) == 0) r.pt[1] = r.pt[0];
            if ($urandom_range(0, 19) == 0) r.pt[3] = r.pt[2];
            r.trk1 = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(1, 3));
            r.trk2 = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(1, 3));
            send_request(r);
        end
        s_tvalid <= 1'b0;

        while (pending_angles.size() != 0) @(posedge aclk);
        tail = 0;
        while (tail < 2 * LAT) begin
            @(posedge aclk);
            tail++;
        end
        if (mismatches == 0 && pending_angles.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
